FILE: rtl/bst_pkg.sv
// shared types and constants of the bounded set table
package bst_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_ITEM_WIDTH = 32;

   localparam int CMD_W   = 2;
   localparam int ITEM_W  = 32;
   localparam int RANK_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic [COUNT_W-1:0] MAX_ITEMS_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 2'd0,
      CMD_ERASE    = 2'd1,
      CMD_CONTAINS = 2'd2,
      CMD_GET      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHIFT,
      ST_PICK,
      ST_LOAD,
      ST_COUNT,
      ST_DONE
   } state_type;

   // one result of the controller
   typedef struct packed {
      logic                 is_empty;
      logic [COUNT_W-1:0]   count;
      logic [ITEM_W-1:0]    found_item;
      logic                 ok;
   } rsp_type;

endpackage

FILE: rtl/bst_ram.sv
// generic simple dual-port ram with registered read
module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/bst_seq.sv
// command sequencer: scans, compacts and ranks the entries held in the ram
module bst_seq
   import bst_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int ITEM_WIDTH = DEF_ITEM_WIDTH,
   localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2),
   localparam int SW = (ITEM_WIDTH < ITEM_W) ? ITEM_WIDTH : ITEM_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               idle,
   input  cmd_type            cmd,
   input  logic [ITEM_W-1:0]  item,
   input  logic [RANK_W-1:0]  rank,
   input  logic [COUNT_W-1:0] max_items,
   output logic [AW-1:0]      ram_raddr,
   input  logic [SW-1:0]      ram_rdata,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output logic [SW-1:0]      ram_wdata,
   output logic               res_valid,
   input  logic               res_take,
   output rsp_type            res
);

   localparam int HW = $clog2(CAPACITY + 1);
   localparam int CW = (HW > RANK_W) ? HW : RANK_W;
   localparam int LW = (HW > COUNT_W) ? HW : COUNT_W;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [SW-1:0]      v_ff, v_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [HW-1:0]      held_ff, held_in;
   logic [HW-1:0]      scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [HW-1:0]      pidx_ff, pidx_in;
   logic [HW-1:0]      j_ff, j_in;
   logic [HW-1:0]      smaller_ff, smaller_in;
   logic [SW-1:0]      cand_ff, cand_in;
   logic               ok_ff, ok_in;
   logic [ITEM_W-1:0]  got_ff, got_in;

   logic issue, last, hit, room, rank_ok, rank_hit;

   // scan bookkeeping shared by lookup, compaction and counting
   assign issue    = scan_ff < held_ff;
   assign last     = !pend_ff && (scan_ff == held_ff);
   assign hit      = pend_ff && (ram_rdata == v_ff);
   assign room     = (LW'(held_ff) < LW'(max_items)) && (LW'(held_ff) < LW'(CAPACITY));
   assign rank_ok  = CW'(rank) < CW'(held_ff);
   assign rank_hit = CW'(smaller_ff) == CW'(rank_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
      end
      cmd_ff     <= cmd_in;
      v_ff       <= v_in;
      rank_ff    <= rank_in;
      scan_ff    <= scan_in;
      pidx_ff    <= pidx_in;
      j_ff       <= j_in;
      smaller_ff <= smaller_in;
      cand_ff    <= cand_in;
      ok_ff      <= ok_in;
      got_ff     <= got_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (cmd == CMD_GET) begin
                  state_in = rank_ok ? ST_PICK : ST_DONE;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (hit) begin
               state_in = (cmd_ff == CMD_ERASE) ? ST_SHIFT : ST_DONE;
            end else if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_PICK:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_COUNT;
         ST_COUNT: begin
            if (last) begin
               state_in = rank_hit ? ST_DONE : ST_PICK;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in     = cmd_ff;
      v_in       = v_ff;
      rank_in    = rank_ff;
      held_in    = held_ff;
      scan_in    = scan_ff;
      pend_in    = pend_ff;
      pidx_in    = pidx_ff;
      j_in       = j_ff;
      smaller_in = smaller_ff;
      cand_in    = cand_ff;
      ok_in      = ok_ff;
      got_in     = got_ff;
      ram_raddr  = scan_ff[AW-1:0];
      ram_we     = 1'b0;
      ram_waddr  = held_ff[AW-1:0];
      ram_wdata  = v_ff;

      // read issue for the scanning states
      if (state_ff == ST_FIND || state_ff == ST_SHIFT || state_ff == ST_COUNT) begin
         pend_in = issue;
         pidx_in = scan_ff;
         if (issue) begin
            scan_in = scan_ff + HW'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in  = cmd;
               v_in    = item[SW-1:0];
               rank_in = rank;
               ok_in   = 1'b0;
               got_in  = '0;
               scan_in = '0;
               pend_in = 1'b0;
               j_in    = '0;
            end
         end
         ST_FIND: begin
            if (hit) begin
               ok_in   = (cmd_ff == CMD_CONTAINS);
               scan_in = pidx_ff + HW'(1);
               pend_in = 1'b0;
            end else if (last) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (room) begin
                        ram_we  = 1'b1;
                        held_in = held_ff + HW'(1);
                        ok_in   = 1'b1;
                     end
                  end
                  default: ok_in = 1'b0;
               endcase
            end
         end
         ST_SHIFT: begin
            // entry read last cycle moves down by one
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(pidx_ff - HW'(1));
               ram_wdata = ram_rdata;
            end
            if (last) begin
               held_in = held_ff - HW'(1);
               ok_in   = 1'b1;
            end
         end
         ST_PICK: begin
            ram_raddr = j_ff[AW-1:0];
         end
         ST_LOAD: begin
            cand_in    = ram_rdata;
            scan_in    = '0;
            pend_in    = 1'b0;
            smaller_in = '0;
         end
         ST_COUNT: begin
            if (pend_ff && (cand_ff > ram_rdata)) begin
               smaller_in = smaller_ff + HW'(1);
            end
            if (last) begin
               if (rank_hit) begin
                  ok_in  = 1'b1;
                  got_in = ITEM_W'(cand_ff);
               end else begin
                  j_in = j_ff + HW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   assign idle           = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_DONE);
   assign res.ok         = ok_ff;
   assign res.found_item = got_ff;
   assign res.count      = COUNT_W'(held_ff);
   assign res.is_empty   = (held_ff == '0);

endmodule

FILE: rtl/bounded_set_table.sv
// top level of the bounded set table: ports, limit register, entry ram, result register
//
// keeps a set of distinct unsigned items in an on-chip ram, in insertion order
// req channel: one transaction per command, req_tuser carries the opcode
//   (insert, erase, contains, get by rank), req_tdata the item and the rank
// rsp channel: exactly one transaction per command, carrying the success flag,
//   the item found by get (zero otherwise), the count held and an empty flag
// csr port: csr_we writes csr_wdata into the item limit, which takes effect
//   for later inserts; items already held are kept if the limit drops
// the single ram read port sets the pace, with n items held: contains and
//   insert scan the held entries once, erase scans them and shifts the
//   entries after the hit down, and get by rank makes one full scan for every
//   candidate in insertion order; a rank not below n answers without a scan
// one command is worked at a time; req_tready is high only while the
//   sequencer is idle
// the result sits in an output register, so the next command is accepted
//   while an earlier result waits for rsp_tready; a second finished result
//   waits inside the sequencer until the register frees up
// reset empties the set and sets the limit to 64; ram contents need no clear
module bounded_set_table
   import bst_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int ITEM_WIDTH = DEF_ITEM_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,  // item[31:0], rank[37:32], zero pad
   input  logic [CMD_W-1:0]   req_tuser,  // cmd[1:0]
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [47:0]        rsp_tdata,  // ok[0], found_item[32:1], count[39:33],
                                          // is_empty[40], zero pad
   // limit register
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
   localparam int SW = (ITEM_WIDTH < ITEM_W) ? ITEM_WIDTH : ITEM_W;

   logic [COUNT_W-1:0] max_items_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic          seq_idle;
   logic          start;
   logic          res_valid;
   logic          res_take;
   rsp_type       res;
   logic [AW-1:0] ram_raddr;
   logic [SW-1:0] ram_rdata;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [SW-1:0] ram_wdata;

   // limit register, to be written only while the block is idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         max_items_ff <= MAX_ITEMS_RESET;
      end else if (csr_we) begin
         max_items_ff <= csr_wdata;
      end
   end

   assign req_tready = seq_idle;
   assign start      = req_tvalid && seq_idle;

   // entry store
   bst_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bst_seq #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .idle      (seq_idle),
      .cmd       (cmd_type'(req_tuser)),
      .item      (req_tdata[ITEM_W-1:0]),
      .rank      (req_tdata[ITEM_W +: RANK_W]),
      .max_items (max_items_ff),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   // output register: free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

FILE: tb/bounded_set_table_tb.sv
// testbench for the bounded set table: directed and random commands checked against a local model
`timescale 1ns / 100ps

module bounded_set_table_tb;
   import bst_pkg::*;

   localparam int CAP           = DEF_CAPACITY;
   localparam int POOL_SIZE     = 96;
   localparam int SEG_ITEMS     = 115;
   localparam int SETTLE_CYCLES = 20;
   // watchdog bound on the whole run, with wide margin over the slowest gets at full occupancy
   localparam int CYCLE_LIMIT   = 25_000_000;

   // tracks the set as the block should hold it and the answers still owed
   class set_ledger;
      logic [ITEM_W-1:0] members[CAP];
      int unsigned       held;
      int unsigned       limit;
      rsp_type           answers_due[$];
      int unsigned       mismatches;
      int unsigned       op_counts[4];
      int unsigned       successes;
      int unsigned       peak_held;

      function new();
         held       = 0;
         limit      = MAX_ITEMS_RESET;
         mismatches = 0;
         successes  = 0;
         peak_held  = 0;
         foreach (op_counts[i]) op_counts[i] = 0;
      endfunction

      function void set_limit(logic [COUNT_W-1:0] value);
         limit = (value < CAP) ? value : CAP;
      endfunction

      // position of value among the held members, or held if absent
      function int unsigned position_of(logic [ITEM_W-1:0] value);
         for (int unsigned i = 0; i < held; i++) begin
            if (members[i] == value) return i;
         end
         return held;
      endfunction

      function logic [ITEM_W-1:0] any_member();
         if (held == 0) return '0;
         return members[$urandom_range(held - 1)];
      endfunction

      function void note_command(cmd_type cmd, logic [ITEM_W-1:0] value,
                                 logic [RANK_W-1:0] rank);
         rsp_type     ans;
         int unsigned pos;
         int unsigned smaller;
         ans = '0;
         op_counts[cmd]++;
         case (cmd)
            CMD_INSERT: begin
               if (position_of(value) == held && held < limit) begin
                  members[held] = value;
                  held++;
                  ans.ok = 1'b1;
               end
            end
            CMD_ERASE: begin
               pos = position_of(value);
               if (pos < held) begin
                  for (int unsigned j = pos; j + 1 < held; j++) members[j] = members[j + 1];
                  held--;
                  ans.ok = 1'b1;
               end
            end
            CMD_CONTAINS: begin
               ans.ok = (position_of(value) < held);
            end
            default: begin
               // rank r is the member with exactly r smaller members
               if (rank < held) begin
                  for (int unsigned j = 0; j < held && !ans.ok; j++) begin
                     smaller = 0;
                     for (int unsigned k = 0; k < held; k++) begin
                        if (members[j] > members[k]) smaller++;
                     end
                     if (smaller == rank) begin
                        ans.found_item = members[j];
                        ans.ok         = 1'b1;
                     end
                  end
               end
            end
         endcase
         ans.count    = COUNT_W'(held);
         ans.is_empty = (held == 0);
         if (ans.ok) successes++;
         if (held > peak_held) peak_held = held;
         answers_due.push_back(ans);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: ok=%0b item=%h count=%0d empty=%0b",
                        got.ok, got.found_item, got.count, got.is_empty);
            return;
         end
         want = answers_due.pop_front();
         if (got.ok !== want.ok || got.found_item !== want.found_item ||
             got.count !== want.count || got.is_empty !== want.is_empty) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected ok=%0b item=%h count=%0d empty=%0b,",
                        want.ok, want.found_item, want.count, want.is_empty,
                        " got ok=%0b item=%h count=%0d empty=%0b",
                        got.ok, got.found_item, got.count, got.is_empty);
         end
      endfunction
   endclass

   // every input starts at a known value, reset asserted from time zero
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [39:0]        req_tdata  = '0;   // item[31:0], rank[37:32], zero pad
   logic [CMD_W-1:0]   req_tuser  = '0;   // cmd[1:0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [47:0]        rsp_tdata;         // ok[0], found_item[32:1], count[39:33], is_empty[40]
   logic               csr_we     = 1'b0;
   logic [COUNT_W-1:0] csr_wdata  = '0;

   set_ledger         ledger = new();
   logic [ITEM_W-1:0] item_pool[POOL_SIZE];
   int unsigned       tx_idle_pct  = 30;
   int unsigned       rx_idle_pct  = 86;
   int unsigned       limit_writes = 0;
   int unsigned       cycle_count  = 0;

   always #1 clock = ~clock;

   bounded_set_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // result side: values read right after the edge are the ones the edge saw,
   // since the block updates its registers in the nonblocking region
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            ledger.check_result(rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]));
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, ledger.answers_due.size());
         $display("bounded_set_table_tb: FAIL");
         $finish;
      end
   end

   // one command transaction; valid stays high into the next call unless it idles
   task automatic send_command(cmd_type cmd, logic [ITEM_W-1:0] value,
                               logic [RANK_W-1:0] rank);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, rank, value};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      ledger.note_command(cmd, value, rank);
   endtask

   // hold off the sender until every owed answer has come back
   task automatic wait_all_answered();
      req_tvalid <= 1'b0;
      while (ledger.answers_due.size() != 0) @(posedge clock);
   endtask

   // the limit only changes with the block idle
   task automatic write_limit(logic [COUNT_W-1:0] value);
      wait_all_answered();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      ledger.set_limit(value);
      limit_writes++;
   endtask

   // mostly pool values so that duplicates, hits and full sets happen often
   function automatic logic [ITEM_W-1:0] pick_item();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 65) return item_pool[$urandom_range(POOL_SIZE - 1)];
      if (roll < 80 && ledger.held > 0) return ledger.any_member();
      return $urandom();
   endfunction

   // ranks near the occupancy most of the time, anywhere otherwise
   function automatic logic [RANK_W-1:0] pick_rank();
      int unsigned top;
      top = (ledger.held > 63) ? 63 : ledger.held;
      if ($urandom_range(99) < 70) return RANK_W'($urandom_range(top));
      return RANK_W'($urandom_range(63));
   endfunction

   task automatic run_segment(int unsigned n, int unsigned insert_wt);
      int unsigned roll;
      int unsigned erase_top;
      int unsigned contains_top;
      erase_top    = insert_wt + (100 - insert_wt) * 2 / 5;
      contains_top = erase_top + (100 - insert_wt) * 3 / 10;
      for (int unsigned i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < insert_wt)
            send_command(CMD_INSERT, pick_item(), RANK_W'($urandom_range(63)));
         else if (roll < erase_top)
            send_command(CMD_ERASE, pick_item(), RANK_W'($urandom_range(63)));
         else if (roll < contains_top)
            send_command(CMD_CONTAINS, pick_item(), RANK_W'($urandom_range(63)));
         else
            send_command(CMD_GET, $urandom(), pick_rank());
      end
   endtask

   // limit and insert share per segment; extremes 0, 1, 64 and above capacity
   int unsigned seg_limit[8]  = '{127, 64, 0, 7, 1, 64, 40, 3};
   int unsigned seg_insert[8] = '{60, 45, 30, 50, 50, 65, 45, 40};

   initial begin
      item_pool[0] = '0;
      item_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) item_pool[i] = $urandom();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty set, extremes of item and rank, every command
      send_command(CMD_GET, 32'hFFFF_FFFF, 6'd0);
      send_command(CMD_CONTAINS, 32'h0000_0000, 6'd63);
      send_command(CMD_ERASE, 32'h0000_0000, 6'd0);
      send_command(CMD_INSERT, 32'h0000_0000, 6'd63);
      send_command(CMD_INSERT, 32'hFFFF_FFFF, 6'd0);
      send_command(CMD_INSERT, 32'h0000_0000, 6'd0);     // duplicate refused
      send_command(CMD_INSERT, 32'h8000_0000, 6'd0);
      send_command(CMD_INSERT, 32'h0000_0001, 6'd0);
      send_command(CMD_CONTAINS, 32'hFFFF_FFFF, 6'd0);
      send_command(CMD_CONTAINS, 32'h0000_0002, 6'd0);
      send_command(CMD_GET, 32'h0000_0000, 6'd0);
      send_command(CMD_GET, 32'hA5A5_A5A5, 6'd1);        // item ignored by get
      send_command(CMD_GET, 32'h0000_0000, 6'd3);
      send_command(CMD_GET, 32'h0000_0000, 6'd4);        // rank equal to count
      send_command(CMD_GET, 32'h0000_0000, 6'd63);
      send_command(CMD_ERASE, 32'h8000_0000, 6'd0);      // middle entry, gap closes
      send_command(CMD_ERASE, 32'h8000_0000, 6'd0);      // now absent

      // limit dropped below the count: held items stay, inserts refused until erases bring the count below it
      write_limit(7'd2);
      send_command(CMD_INSERT, 32'h0000_0007, 6'd0);
      send_command(CMD_ERASE, 32'h0000_0000, 6'd0);
      send_command(CMD_INSERT, 32'h0000_0007, 6'd0);     // at the limit
      send_command(CMD_ERASE, 32'h0000_0001, 6'd0);
      send_command(CMD_INSERT, 32'h0000_0007, 6'd0);

      write_limit(7'd0);
      send_command(CMD_INSERT, 32'h0000_0009, 6'd0);
      send_command(CMD_ERASE, 32'h0000_0007, 6'd0);
      send_command(CMD_ERASE, 32'hFFFF_FFFF, 6'd0);      // back to empty

      // random segments under three idle patterns
      for (int s = 0; s < 8; s++) begin
         write_limit(COUNT_W'(seg_limit[s]));
         if (s < 3) begin
            tx_idle_pct = 30;
            rx_idle_pct = 86;
         end else if (s < 6) begin
            tx_idle_pct = 86;
            rx_idle_pct = 30;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         run_segment(SEG_ITEMS, seg_insert[s]);
      end

      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d insert, %0d erase, %0d contains, %0d get commands, %0d succeeded",
               ledger.op_counts[CMD_INSERT], ledger.op_counts[CMD_ERASE],
               ledger.op_counts[CMD_CONTAINS], ledger.op_counts[CMD_GET], ledger.successes);
      $display("peak occupancy %0d of %0d, %0d limit writes, %0d mismatches",
               ledger.peak_held, CAP, limit_writes, ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.answers_due.size() == 0) begin
         $display("bounded_set_table_tb: PASS");
      end else begin
         $display("bounded_set_table_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/bst_pkg.sv
rtl/bst_ram.sv
rtl/bst_seq.sv
rtl/bounded_set_table.sv
tb/bounded_set_table_tb.sv
